### rtl/lpsbe_pkg.sv
// lpsbe_pkg: shared types and constants for the led pixel spi bit encoder
// no dependencies; used by every module of the block
`default_nettype none

package lpsbe_pkg;

	// spi byte symbols
	localparam logic [7:0] SYM_ONE  = 8'h7C;
	localparam logic [7:0] SYM_ZERO = 8'h60;
	localparam logic [7:0] SYM_IDLE = 8'h00;

	localparam int CHAN_W         = 16;
	localparam int PIX_W          = 3 * CHAN_W;
	localparam int BITS_PER_PIXEL = 48;
	localparam int REP_W          = 10;
	localparam int PSENT_W        = 5;

	// classification of one accepted pixel
	typedef struct packed {
		logic             lead;
		logic             ovf;
		logic             trail;
		logic [REP_W-1:0] trail_rep;
	} cmd_ctl_t;

	// one queued command: control plus scaled green, red, blue
	typedef struct packed {
		cmd_ctl_t         ctl;
		logic [PIX_W-1:0] pix;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/led_pixel_spi_bit_encoder_top.sv
// led_pixel_spi_bit_encoder_top: top level of the led pixel spi bit encoder
// depends on lpsbe_pkg, lpsbe_front, lpsbe_cmdq, lpsbe_back
//
// Each pixel item (16-bit green, red, blue) is scaled by the brightness register as
// round(v*b/65535) and expanded into 48 spi byte results, green first, msb first,
// 0x7C for a one and 0x60 for a zero, one result per clock while out_ready is high.
// The first pixel of a frame is preceded by a zero run of RESET_LEN bytes; a pixel with
// last_pixel set is followed by a zero run covering the unused slots (48 bytes each)
// plus RESET_LEN, marked frame_done. A pixel beyond MAX_PIXELS in a frame gives a
// single overflow marker result instead of its bits. An item gives 48 to 50 results,
// one per clock while out_ready is high, from the one-result-per-cycle back sequencer;
// an overflowed pixel gives one or two. The front scales the next pixels in a two-stage
// pipeline and parks them in a CMDQ_DEPTH-entry queue, so in_ready stays high while the
// back is busy until the queue and both stages fill. Write brightness only while idle.
`default_nettype none

module led_pixel_spi_bit_encoder_top #(
	parameter int MAX_PIXELS = 8,
	parameter int RESET_LEN  = 220,
	parameter int CMDQ_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] brightness,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [15:0] green,
	input  wire  [15:0] red,
	input  wire  [15:0] blue,
	input  wire         last_pixel,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  spi_byte,
	output logic [9:0]  repeat_res,
	output logic        frame_done,
	output logic        overflow,
	output logic        last
);

	logic            push_valid;
	logic            push_ready;
	lpsbe_pkg::cmd_t push_cmd;
	logic            pop_valid;
	logic            pop_ready;
	lpsbe_pkg::cmd_t pop_cmd;

	// front: frame tracking and channel scaling
	lpsbe_front #(
		.MAX_PIXELS (MAX_PIXELS),
		.RESET_LEN  (RESET_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (brightness),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.green      (green),
		.red        (red),
		.blue       (blue),
		.last_pixel (last_pixel),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// command queue
	lpsbe_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// back: result sequencer
	lpsbe_back #(
		.RESET_LEN (RESET_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.spi_byte   (spi_byte),
		.repeat_res (repeat_res),
		.frame_done (frame_done),
		.overflow   (overflow),
		.last       (last)
	);

	// frame close run is always the last result of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (last && spi_byte == lpsbe_pkg::SYM_IDLE && !overflow))
		else $error("frame close result malformed");

	// bit symbols carry a single repeat and no flags
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && spi_byte != lpsbe_pkg::SYM_IDLE) |->
		(repeat_res == 10'd1 && !frame_done && !overflow))
		else $error("bit symbol result malformed");

	// overflow marker is a lone idle byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (spi_byte == lpsbe_pkg::SYM_IDLE && repeat_res == 10'd1))
		else $error("overflow marker malformed");

	// a pixel item is only pushed to the queue when it has room
	assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> push_valid)
		else $error("front dropped a command while queue full");

endmodule

`default_nettype wire

### rtl/lpsbe_front.sv
// lpsbe_front: accepts pixels, tracks frame state, scales channels by brightness
// depends on lpsbe_pkg
`default_nettype none

module lpsbe_front #(
	parameter int MAX_PIXELS = 8,
	parameter int RESET_LEN  = 220
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [15:0]                   cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [15:0]                   green,
	input  wire  [15:0]                   red,
	input  wire  [15:0]                   blue,
	input  wire                           last_pixel,
	output logic                          push_valid,
	input  wire                           push_ready,
	output lpsbe_pkg::cmd_t               push_cmd
);

	logic [15:0]                          brightness_q;
	logic                                 in_frame_q;
	logic [lpsbe_pkg::PSENT_W-1:0]        psent_q;

	logic                                 valid_s1;
	lpsbe_pkg::cmd_ctl_t                  ctl_s1;
	logic [2:0][31:0]                     prod_s1;

	logic                                 valid_s2;
	lpsbe_pkg::cmd_ctl_t                  ctl_s2;
	logic [2:0][31:0]                     prod_s2;
	logic [2:0][15:0]                     quo_s2;

	logic                                 accept;
	logic                                 s1_move;
	logic                                 s2_free;
	logic [lpsbe_pkg::PSENT_W-1:0]        ps_cur;
	logic [lpsbe_pkg::PSENT_W-1:0]        ps_next;
	logic                                 ovf;
	logic [lpsbe_pkg::PSENT_W-1:0]        unused;
	logic [10:0]                          trail_full;
	lpsbe_pkg::cmd_ctl_t                  ctl_in;
	logic [2:0][15:0]                     chan_in;
	logic [2:0][32:0]                     est_sum;
	logic [2:0][17:0]                     rem;
	logic [2:0][15:0]                     quo;

	assign cfg_ready = 1'b1;

	// pipeline handshake
	assign s2_free  = !valid_s2 || push_ready;
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	// frame classification
	always_comb begin
		ps_cur  = in_frame_q ? psent_q : '0;
		ovf     = (ps_cur >= lpsbe_pkg::PSENT_W'(MAX_PIXELS));
		ps_next = ovf ? ps_cur : ps_cur + 1'b1;
		unused  = (ps_next < lpsbe_pkg::PSENT_W'(MAX_PIXELS)) ?
			lpsbe_pkg::PSENT_W'(MAX_PIXELS) - ps_next : '0;
		trail_full = (11'(unused) << 5) + (11'(unused) << 4) + 11'(RESET_LEN);
		ctl_in.lead      = !in_frame_q;
		ctl_in.ovf       = ovf;
		ctl_in.trail     = last_pixel;
		ctl_in.trail_rep = trail_full[lpsbe_pkg::REP_W-1:0];
		chan_in[0] = green;
		chan_in[1] = red;
		chan_in[2] = blue;
	end

	// frame state and brightness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 16'hFFFF;
			in_frame_q   <= 1'b0;
			psent_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				brightness_q <= cfg_data;
			end
			if (accept) begin
				if (last_pixel) begin
					in_frame_q <= 1'b0;
					psent_q    <= '0;
				end else begin
					in_frame_q <= 1'b1;
					psent_q    <= ps_next;
				end
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// quotient estimate of p / 65535, low by at most one
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			est_sum[c] = {1'b0, prod_s1[c]} + 33'(prod_s1[c][31:16]);
		end
	end

	// stage payloads: multiply, then estimate
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_in;
			for (int c = 0; c < 3; c++) begin
				prod_s1[c] <= 32'(chan_in[c]) * 32'(brightness_q) + 32'd32767;
			end
		end
		if (s1_move) begin
			ctl_s2 <= ctl_s1;
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= prod_s1[c];
				quo_s2[c]  <= est_sum[c][31:16];
			end
		end
	end

	// remainder check and one-step correction
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem[c] = prod_s2[c][17:0] + {2'b00, quo_s2[c]} - {quo_s2[c][1:0], 16'h0000};
			quo[c] = quo_s2[c] + 16'(rem[c] >= 18'd65535);
		end
	end

	assign push_valid    = valid_s2;
	assign push_cmd.ctl  = ctl_s2;
	assign push_cmd.pix  = {quo[0], quo[1], quo[2]};

endmodule

`default_nettype wire

### rtl/lpsbe_cmdq.sv
// lpsbe_cmdq: short command queue between front and back
// depends on lpsbe_pkg
`default_nettype none

module lpsbe_cmdq #(
	parameter int DEPTH = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push_valid,
	output logic            push_ready,
	input  lpsbe_pkg::cmd_t push_cmd,
	output logic            pop_valid,
	input  wire             pop_ready,
	output lpsbe_pkg::cmd_t pop_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lpsbe_pkg::cmd_t  mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lpsbe_back.sv
// lpsbe_back: expands queued commands into spi byte results, one per cycle while out_ready is high
// depends on lpsbe_pkg
`default_nettype none

module lpsbe_back #(
	parameter int RESET_LEN = 220
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          pop_valid,
	output logic                         pop_ready,
	input  lpsbe_pkg::cmd_t              pop_cmd,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [7:0]                   spi_byte,
	output logic [lpsbe_pkg::REP_W-1:0]  repeat_res,
	output logic                         frame_done,
	output logic                         overflow,
	output logic                         last
);

	localparam logic [1:0] PH_LEAD  = 2'd0;
	localparam logic [1:0] PH_BITS  = 2'd1;
	localparam logic [1:0] PH_OVF   = 2'd2;
	localparam logic [1:0] PH_TRAIL = 2'd3;

	logic                              busy_q;
	logic [1:0]                        phase_q;
	logic [5:0]                        bit_idx_q;
	lpsbe_pkg::cmd_ctl_t               ctl_q;
	logic [lpsbe_pkg::PIX_W-1:0]       pix_q;
	logic                              out_valid_q;

	logic                              out_free;
	logic                              step;
	logic                              done_cmd;
	logic                              end_bits;
	logic                              load;
	logic [1:0]                        start_phase;
	logic [7:0]                        e_byte;
	logic [lpsbe_pkg::REP_W-1:0]       e_rep;
	logic                              e_done;
	logic                              e_ovf;
	logic                              e_last;

	assign out_free  = !out_valid_q || out_ready;
	assign step      = busy_q && out_free;
	assign end_bits  = (bit_idx_q == 6'(lpsbe_pkg::BITS_PER_PIXEL - 1));
	assign pop_ready = !busy_q || (step && done_cmd);
	assign load      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;

	// first phase of a new command
	always_comb begin
		if (pop_cmd.ctl.lead) begin
			start_phase = PH_LEAD;
		end else if (pop_cmd.ctl.ovf) begin
			start_phase = PH_OVF;
		end else begin
			start_phase = PH_BITS;
		end
	end

	// result for the current phase
	always_comb begin
		e_byte   = lpsbe_pkg::SYM_IDLE;
		e_rep    = lpsbe_pkg::REP_W'(1);
		e_done   = 1'b0;
		e_ovf    = 1'b0;
		e_last   = 1'b0;
		done_cmd = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				e_rep = lpsbe_pkg::REP_W'(RESET_LEN);
			end
			PH_BITS: begin
				e_byte   = pix_q[lpsbe_pkg::PIX_W-1] ? lpsbe_pkg::SYM_ONE : lpsbe_pkg::SYM_ZERO;
				e_last   = end_bits && !ctl_q.trail;
				done_cmd = e_last;
			end
			PH_OVF: begin
				e_ovf    = 1'b1;
				e_last   = !ctl_q.trail;
				done_cmd = e_last;
			end
			PH_TRAIL: begin
				e_rep    = ctl_q.trail_rep;
				e_done   = 1'b1;
				e_last   = 1'b1;
				done_cmd = 1'b1;
			end
			default: begin
				done_cmd = 1'b1;
			end
		endcase
	end

	// sequencer control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_LEAD;
			bit_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q    <= 1'b1;
				phase_q   <= start_phase;
				bit_idx_q <= '0;
			end else if (step && done_cmd) begin
				busy_q <= 1'b0;
			end else if (step) begin
				case (phase_q)
					PH_LEAD: begin
						phase_q <= ctl_q.ovf ? PH_OVF : PH_BITS;
					end
					PH_BITS: begin
						bit_idx_q <= bit_idx_q + 1'b1;
						if (end_bits) begin
							phase_q <= PH_TRAIL;
						end
					end
					PH_OVF: begin
						phase_q <= PH_TRAIL;
					end
					default: begin
						phase_q <= PH_TRAIL;
					end
				endcase
			end
		end
	end

	// command payload and output fields
	always_ff @(posedge clk) begin
		if (load) begin
			ctl_q <= pop_cmd.ctl;
			pix_q <= pop_cmd.pix;
		end else if (step && phase_q == PH_BITS) begin
			pix_q <= {pix_q[lpsbe_pkg::PIX_W-2:0], 1'b0};
		end
		if (step) begin
			spi_byte   <= e_byte;
			repeat_res <= e_rep;
			frame_done <= e_done;
			overflow   <= e_ovf;
			last       <= e_last;
		end
	end

endmodule

`default_nettype wire
